// ===== hw/rtl/eq3_pkg.sv =====
// eq3_pkg: types, preset codes, gain table and per-sample band math
// for the three-band stereo equalizer. No dependencies.
`default_nettype none

package eq3_pkg;

  localparam logic [2:0] PRE_FLAT  = 3'd0;
  localparam logic [2:0] PRE_BASS  = 3'd1;
  localparam logic [2:0] PRE_ROCK  = 3'd2;
  localparam logic [2:0] PRE_POP   = 3'd3;
  localparam logic [2:0] PRE_VOCAL = 3'd4;

  localparam logic signed [21:0] SAT_MAX = 22'sd32767;
  localparam logic signed [21:0] SAT_MIN = -22'sd32768;

  typedef logic signed [15:0] sample_t;

  typedef struct packed {
    logic [8:0] bass;
    logic [8:0] mid;
    logic [8:0] treble;
  } gain_t;

  typedef struct packed {
    logic signed [15:0] low;
    logic signed [15:0] fast;
    logic signed [16:0] hi;
    logic signed [16:0] mid;
  } band_t;

  function automatic gain_t preset_gains(input logic [2:0] preset);
    gain_t g;
    case (preset)
      PRE_BASS:  g = '{bass: 9'd380, mid: 9'd240, treble: 9'd240};
      PRE_ROCK:  g = '{bass: 9'd340, mid: 9'd220, treble: 9'd320};
      PRE_POP:   g = '{bass: 9'd280, mid: 9'd300, treble: 9'd300};
      PRE_VOCAL: g = '{bass: 9'd200, mid: 9'd360, treble: 9'd280};
      default:   g = '{bass: 9'd256, mid: 9'd256, treble: 9'd256};
    endcase
    return g;
  endfunction

  // One-pole trackers and band split for one sample.
  function automatic band_t band_update(input sample_t x, input sample_t low,
                                        input sample_t fast);
    logic signed [16:0] x17;
    logic signed [16:0] lo17;
    logic signed [16:0] fa17;
    logic signed [16:0] d_lo;
    logic signed [16:0] lo_sum;
    logic signed [19:0] d_fa;
    logic signed [19:0] d_fa7;
    logic signed [16:0] fa_step;
    logic signed [16:0] fa_sum;
    band_t b;
    x17     = 17'(x);
    lo17    = 17'(low);
    fa17    = 17'(fast);
    d_lo    = x17 - lo17;
    lo_sum  = lo17 + (d_lo >>> 5);
    d_fa    = 20'(x17 - fa17);
    d_fa7   = (d_fa <<< 3) - d_fa;
    fa_step = d_fa7[19:3];
    fa_sum  = fa17 + fa_step;
    b.low   = lo_sum[15:0];
    b.fast  = fa_sum[15:0];
    b.hi    = x17 - 17'(b.fast);
    b.mid   = 17'(b.fast) - 17'(b.low);
    return b;
  endfunction

  // Weighted band sum, floor shift by 8, saturate to 16 bits.
  function automatic sample_t band_mix(input sample_t low, input logic signed [16:0] mid,
                                       input logic signed [16:0] hi, input gain_t g);
    logic signed [26:0] p0;
    logic signed [26:0] p1;
    logic signed [26:0] p2;
    logic signed [29:0] acc;
    logic signed [21:0] sh;
    sample_t y;
    p0  = 27'(low) * 27'($signed({1'b0, g.bass}));
    p1  = 27'(mid) * 27'($signed({1'b0, g.mid}));
    p2  = 27'(hi) * 27'($signed({1'b0, g.treble}));
    acc = 30'(p0) + 30'(p1) + 30'(p2);
    sh  = acc[29:8];
    if (sh > SAT_MAX) begin
      y = 16'sh7FFF;
    end else if (sh < SAT_MIN) begin
      y = 16'sh8000;
    end else begin
      y = sh[15:0];
    end
    return y;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/three_band_stereo_equalizer.sv =====
// three_band_stereo_equalizer: top level, two-stage stereo equalizer.
// Depends on eq3_pkg for gain table and band math.
//
// Usage:
//   Input channel in_valid/in_stall carries one stereo frame per item
//   (in_left_in, in_right_in, in_frame_last_in). Output channel
//   out_valid/out_stall returns one equalized frame per item, in order.
//   cfg_wr_en/cfg_wr_data write the 3-bit preset; every write also clears
//   the filter trackers. Write only while the block is idle.
//   An accepted frame passes the stage 1 and then the output registers
//   to out_valid; throughput is one item per cycle while out_stall is
//   low. Stage 1 updates trackers and splits bands, which must finish in
//   the accept cycle for the next frame; stage 2 weights, sums, saturates.
//   Flat preset (and codes above vocal) pass samples through and leave
//   the trackers untouched.
//   Reset (synchronous, rst_n low) empties both stages, selects flat and
//   zeroes the trackers.
//   When out_stall is high the result holds; stage 1 still takes one more
//   item if empty, after which in_stall rises until the output drains.
`default_nettype none

module three_band_stereo_equalizer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [2:0]          cfg_wr_data,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire eq3_pkg::sample_t    in_left_in,
  input  wire eq3_pkg::sample_t    in_right_in,
  input  wire logic                in_frame_last_in,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      eq3_pkg::sample_t    out_left_out,
  output      eq3_pkg::sample_t    out_right_out,
  output      logic                out_frame_last_out
);
  import eq3_pkg::*;

  logic [2:0] preset_r;
  sample_t    low_l_r, low_r_r, fast_l_r, fast_r_r;

  logic       s1_valid_r;
  band_t      s1_bl_r, s1_br_r;
  sample_t    s1_xl_r, s1_xr_r;
  gain_t      s1_gain_r;
  logic       s1_bypass_r;
  logic       s1_last_r;

  logic       out_valid_r;
  sample_t    out_l_r, out_r_r;
  logic       out_last_r;

  logic       s2_ld, s1_ld, bypass;
  band_t      bl_nxt, br_nxt;

  assign s2_ld    = !out_valid_r || !out_stall;
  assign s1_ld    = !s1_valid_r || s2_ld;
  assign in_stall = !s1_ld;
  assign bypass   = !(preset_r inside {[PRE_BASS:PRE_VOCAL]});

  assign bl_nxt = band_update(in_left_in, low_l_r, fast_l_r);
  assign br_nxt = band_update(in_right_in, low_r_r, fast_r_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preset_r <= PRE_FLAT;
      low_l_r  <= '0;
      low_r_r  <= '0;
      fast_l_r <= '0;
      fast_r_r <= '0;
    end else if (cfg_wr_en) begin
      preset_r <= cfg_wr_data;
      low_l_r  <= '0;
      low_r_r  <= '0;
      fast_l_r <= '0;
      fast_r_r <= '0;
    end else if (in_valid && s1_ld && !bypass) begin
      low_l_r  <= bl_nxt.low;
      low_r_r  <= br_nxt.low;
      fast_l_r <= bl_nxt.fast;
      fast_r_r <= br_nxt.fast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ld) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ld && in_valid) begin
      s1_bl_r     <= bl_nxt;
      s1_br_r     <= br_nxt;
      s1_xl_r     <= in_left_in;
      s1_xr_r     <= in_right_in;
      s1_gain_r   <= preset_gains(preset_r);
      s1_bypass_r <= bypass;
      s1_last_r   <= in_frame_last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ld) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ld && s1_valid_r) begin
      out_last_r <= s1_last_r;
      if (s1_bypass_r) begin
        out_l_r <= s1_xl_r;
        out_r_r <= s1_xr_r;
      end else begin
        out_l_r <= band_mix(s1_bl_r.low, s1_bl_r.mid, s1_bl_r.hi, s1_gain_r);
        out_r_r <= band_mix(s1_br_r.low, s1_br_r.mid, s1_br_r.hi, s1_gain_r);
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left_out       = out_l_r;
  assign out_right_out      = out_r_r;
  assign out_frame_last_out = out_last_r;

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in pipeline");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (low_l_r == '0 && low_r_r == '0 && fast_l_r == '0 && fast_r_r == '0))
    else $error("preset write did not clear trackers");

  a_bypass_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && bypass && !cfg_wr_en) |=>
      ($stable(low_l_r) && $stable(low_r_r) && $stable(fast_l_r) && $stable(fast_r_r)))
    else $error("trackers moved in bypass");

  a_s1_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_ld) |=> out_valid_r)
    else $error("stage 1 item lost");

endmodule

`default_nettype wire
